// ----- sv/ialu_pkg.sv -----
// Shared types and constants for the integer ALU with power.
package ialu_pkg;

  // Fixed field widths of the stream payloads.
  localparam int MODE_W    = 4;
  localparam int FIELD_W   = 32;
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 32;

  // Multiplier bits retired per cycle by each shift-add unit.
  localparam int MUL_DIGIT = 8;

  // Operation codes.
  typedef enum logic [MODE_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_REM = 4'd4,
    OP_POW = 4'd5,
    OP_EQ  = 4'd6,
    OP_NE  = 4'd7,
    OP_LT  = 4'd8,
    OP_LE  = 4'd9,
    OP_GE  = 4'd10,
    OP_GT  = 4'd11
  } mode_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_DIV,
    ST_POW_TEST,
    ST_POW_MUL,
    ST_POW_UPD,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul_init;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic pow_init;
    logic pow_step_init;
    logic pow_update;
    logic res_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_t mode;
    logic  div_zero;
    logic  exp_neg;
    logic  exp_zero;
    logic  last_step;
    logic  out_busy;
  } stat_t;

endpackage

// ----- sv/ialu_ctrl.sv -----
// Controller state machine that sequences the ALU datapath.
module ialu_ctrl
  import ialu_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  stat_t  stat,
  output logic   in_ready,
  output cmd_t   cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (stat.mode)
          OP_MUL: state_next = ST_MUL;
          OP_DIV, OP_REM: state_next = stat.div_zero ? ST_FINISH : ST_DIV;
          OP_POW: state_next = stat.exp_neg ? ST_FINISH : ST_POW_TEST;
          default: state_next = ST_FINISH;
        endcase
      end
      ST_MUL: begin
        if (stat.last_step) state_next = ST_FINISH;
      end
      ST_DIV: begin
        if (stat.last_step) state_next = ST_FINISH;
      end
      ST_POW_TEST: begin
        state_next = stat.exp_zero ? ST_FINISH : ST_POW_MUL;
      end
      ST_POW_MUL: begin
        if (stat.last_step) state_next = ST_POW_UPD;
      end
      ST_POW_UPD: begin
        state_next = ST_POW_TEST;
      end
      ST_FINISH: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Command outputs; no request is taken while reset is held.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      ST_DECODE: begin
        case (stat.mode)
          OP_MUL: cmd.mul_init = 1'b1;
          OP_DIV, OP_REM: cmd.div_init = !stat.div_zero;
          OP_POW: cmd.pow_init = !stat.exp_neg;
          default: cmd = '0;
        endcase
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_POW_TEST: begin
        cmd.pow_step_init = !stat.exp_zero;
      end
      ST_POW_MUL: begin
        cmd.mul_step = 1'b1;
      end
      ST_POW_UPD: begin
        cmd.pow_update = 1'b1;
      end
      ST_FINISH: begin
        cmd.res_load = !stat.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- sv/ialu_dp.sv -----
// Datapath: operand registers, shift-add multipliers, divider and output register.
module ialu_dp
  import ialu_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic [S_TDATA_W-1:0] in_data,
  input  logic                 out_ready,
  output stat_t                stat,
  output logic                 out_valid,
  output logic [FIELD_W-1:0]   out_value,
  output logic                 out_error
);

  localparam int W         = DATA_WIDTH;
  localparam int MUL_STEPS = (DATA_WIDTH + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int CNT_W     = $clog2(DATA_WIDTH);

  mode_t          mode_reg;
  logic [W-1:0]   a_reg;
  logic [W-1:0]   b_reg;
  logic [CNT_W-1:0] cnt;

  // Two shift-add multiplier units.
  logic [W-1:0]   mcand_a, mplier_a, prod_a;
  logic [W-1:0]   mcand_b, mplier_b, prod_b;
  logic [W+MUL_DIGIT-1:0] pp_a, pp_b;

  // Power loop registers.
  logic [W-1:0]   acc;
  logic [W-1:0]   base;
  logic [W-1:0]   expo;

  // Restoring divider registers.
  logic [W-1:0]   quo;
  logic [W-1:0]   rmd;
  logic [W-1:0]   dvs;
  logic [W:0]     div_shift;
  logic [W:0]     div_diff;
  logic [W-1:0]   mag_a, mag_b;

  logic [W-1:0]   res;
  logic           res_err;
  logic           a_neg, b_neg;

  assign a_neg = a_reg[W-1];
  assign b_neg = b_reg[W-1];
  assign mag_a = a_neg ? (~a_reg + 1'b1) : a_reg;
  assign mag_b = b_neg ? (~b_reg + 1'b1) : b_reg;

  assign pp_a = mcand_a * mplier_a[MUL_DIGIT-1:0];
  assign pp_b = mcand_b * mplier_b[MUL_DIGIT-1:0];

  assign div_shift = {rmd, quo[W-1]};
  assign div_diff  = div_shift - {1'b0, dvs};

  // Operand capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_reg <= mode_t'(in_data[MODE_W-1:0]);
      a_reg    <= W'(signed'(in_data[MODE_W +: FIELD_W]));
      b_reg    <= W'(signed'(in_data[MODE_W+FIELD_W +: FIELD_W]));
    end
  end

  // Shared step counter: loaded with steps minus one, done at zero.
  always_ff @(posedge clk) begin
    if (cmd.mul_init || cmd.pow_step_init) begin
      cnt <= CNT_W'(MUL_STEPS - 1);
    end else if (cmd.div_init) begin
      cnt <= CNT_W'(DATA_WIDTH - 1);
    end else if ((cmd.mul_step || cmd.div_step) && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Multiplier units, one digit of the multiplier per cycle.
  always_ff @(posedge clk) begin
    if (cmd.mul_init) begin
      mcand_a  <= a_reg;
      mplier_a <= b_reg;
      prod_a   <= '0;
    end else if (cmd.pow_step_init) begin
      mcand_a  <= acc;
      mplier_a <= base;
      prod_a   <= '0;
      mcand_b  <= base;
      mplier_b <= base;
      prod_b   <= '0;
    end else if (cmd.mul_step) begin
      prod_a   <= prod_a + pp_a[W-1:0];
      mcand_a  <= mcand_a << MUL_DIGIT;
      mplier_a <= mplier_a >> MUL_DIGIT;
      prod_b   <= prod_b + pp_b[W-1:0];
      mcand_b  <= mcand_b << MUL_DIGIT;
      mplier_b <= mplier_b >> MUL_DIGIT;
    end
  end

  // Square-and-multiply state.
  always_ff @(posedge clk) begin
    if (cmd.pow_init) begin
      acc  <= W'(1);
      base <= a_reg;
      expo <= b_reg;
    end else if (cmd.pow_update) begin
      if (expo[0]) acc <= prod_a;
      base <= prod_b;
      expo <= expo >> 1;
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo <= mag_a;
      rmd <= '0;
      dvs <= mag_b;
    end else if (cmd.div_step) begin
      if (!div_diff[W]) begin
        rmd <= div_diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rmd <= div_shift[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  // Result selection by operation.
  always_comb begin
    res     = '0;
    res_err = 1'b0;
    case (mode_reg)
      OP_ADD: res = a_reg + b_reg;
      OP_SUB: res = a_reg - b_reg;
      OP_MUL: res = prod_a;
      OP_DIV: begin
        if (b_reg == '0) begin
          res_err = 1'b1;
        end else begin
          res = (a_neg != b_neg) ? (~quo + 1'b1) : quo;
        end
      end
      OP_REM: begin
        if (b_reg == '0) begin
          res_err = 1'b1;
        end else begin
          res = a_neg ? (~rmd + 1'b1) : rmd;
        end
      end
      OP_POW: begin
        if (b_neg) begin
          // Only a base of one or minus one survives a negative exponent.
          if (a_reg == '1) begin
            res = b_reg[0] ? '1 : W'(1);
          end else if (a_reg == W'(1)) begin
            res = W'(1);
          end else begin
            res = '0;
          end
        end else begin
          res = acc;
        end
      end
      OP_EQ: res = W'(a_reg == b_reg);
      OP_NE: res = W'(a_reg != b_reg);
      OP_LT: res = W'($signed(a_reg) < $signed(b_reg));
      OP_LE: res = W'($signed(a_reg) <= $signed(b_reg));
      OP_GE: res = W'($signed(a_reg) >= $signed(b_reg));
      OP_GT: res = W'($signed(a_reg) > $signed(b_reg));
      default: res = '0;
    endcase
  end

  // Output register; a new result may load as the old one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_value <= FIELD_W'(signed'(res));
      out_error <= res_err;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.mode      = mode_reg;
    stat.div_zero  = (b_reg == '0);
    stat.exp_neg   = b_neg;
    stat.exp_zero  = (expo == '0);
    stat.last_step = (cnt == '0);
    stat.out_busy  = out_valid && !out_ready;
  end

endmodule

// ----- sv/integer_alu_with_power.sv -----
// Top level of the signed integer ALU with add, subtract, multiply, divide, remainder, power and compares.
// Add, sub, compares and unused codes go from decode straight to the result register;
// mul first steps through the 8-bit-per-cycle shift-add multiplier;
// div and rem first step through the radix-2 divider, which a zero divisor skips.
// pow tests, multiplies and updates once per significant exponent bit, and skips the loop if negative.
// One request in flight; the next is taken in the idle state that follows the result load.
// Synchronous active-high reset returns the controller to idle and empties the output.
module integer_alu_with_power
  import ialu_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata: mode [3:0], left_operand [35:4], right_operand [67:36], zero fill.
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: result_value [31:0].
  output logic [M_TDATA_W-1:0] m_tdata,
  // m_tuser: divide_error [0].
  output logic                 m_tuser
);

  cmd_t  cmd;
  stat_t stat;

  ialu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .stat     (stat),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  ialu_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (s_tdata),
    .out_ready (m_tready),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_value (m_tdata),
    .out_error (m_tuser)
  );

  // A divide error always comes with a zero result.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("divide error with nonzero result");

  // Once a request is taken, no other is accepted in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while busy");

  // A new result never overwrites one that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !(m_tvalid && !m_tready))
    else $error("pending result overwritten");

endmodule

// ----- sim/ialu_result_check.sv -----
// Checker for the integer ALU: predicts each result from the accepted requests and compares.
module ialu_result_check
  import ialu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 m_tuser,
  output int                   mismatches,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result: the wrapped value and the divide error flag.
  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               div_error;
  } alu_answer_t;

  alu_answer_t expected_answers[$];
  alu_answer_t oldest;

  // Integer power by square-and-multiply, with the fixed answers for negative exponents.
  function automatic logic [FIELD_W-1:0] raise_power(logic [FIELD_W-1:0] base,
                                                     logic [FIELD_W-1:0] expo);
    logic [FIELD_W-1:0] acc;
    logic [FIELD_W-1:0] sq;
    logic [FIELD_W-1:0] e;
    if (expo[FIELD_W-1]) begin
      if (base == '1) return expo[0] ? '1 : FIELD_W'(1);
      if (base == FIELD_W'(1)) return FIELD_W'(1);
      return '0;
    end
    acc = FIELD_W'(1);
    sq  = base;
    e   = expo;
    while (e != 0) begin
      if (e[0]) acc = acc * sq;
      sq = sq * sq;
      e  = e >> 1;
    end
    return acc;
  endfunction

  // Expected result of one request.
  function automatic alu_answer_t alu_compute(logic [MODE_W-1:0] op, logic [FIELD_W-1:0] a,
                                              logic [FIELD_W-1:0] b);
    alu_answer_t        ans;
    logic [FIELD_W-1:0] ua;
    logic [FIELD_W-1:0] ub;
    logic [FIELD_W-1:0] q;
    logic [FIELD_W-1:0] m;
    ans = '0;
    ua  = a[FIELD_W-1] ? -a : a;
    ub  = b[FIELD_W-1] ? -b : b;
    case (op)
      OP_ADD: ans.value = a + b;
      OP_SUB: ans.value = a - b;
      OP_MUL: ans.value = a * b;
      OP_DIV, OP_REM: begin
        // A zero divisor flags the error and gives zero.
        if (b == '0) begin
          ans.div_error = 1'b1;
        end else if (op == OP_DIV) begin
          q = ua / ub;
          ans.value = (a[FIELD_W-1] ^ b[FIELD_W-1]) ? -q : q;
        end else begin
          m = ua % ub;
          ans.value = a[FIELD_W-1] ? -m : m;
        end
      end
      OP_POW: ans.value = raise_power(a, b);
      OP_EQ:  ans.value = (a == b) ? FIELD_W'(1) : '0;
      OP_NE:  ans.value = (a != b) ? FIELD_W'(1) : '0;
      OP_LT:  ans.value = ($signed(a) <  $signed(b)) ? FIELD_W'(1) : '0;
      OP_LE:  ans.value = ($signed(a) <= $signed(b)) ? FIELD_W'(1) : '0;
      OP_GE:  ans.value = ($signed(a) >= $signed(b)) ? FIELD_W'(1) : '0;
      OP_GT:  ans.value = ($signed(a) >  $signed(b)) ? FIELD_W'(1) : '0;
      default: ans = '0;
    endcase
    return ans;
  endfunction

  // Record accepted requests and compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      expected_answers.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        expected_answers.insert(expected_answers.size(),
                                alu_compute(s_tdata[3:0], s_tdata[35:4], s_tdata[67:36]));
      end
      if (m_tvalid && m_tready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: result with nothing expected: value %h error %b",
                   $time, m_tdata, m_tuser);
          mismatches++;
        end else begin
          oldest = expected_answers.pop_front();
          if (m_tdata !== oldest.value) begin
            $display("%0t: result_value expected %h actual %h", $time, oldest.value, m_tdata);
            mismatches++;
          end
          if (m_tuser !== oldest.div_error) begin
            $display("%0t: divide_error expected %b actual %b",
                     $time, oldest.div_error, m_tuser);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_answers.size();
  end

endmodule

// ----- sim/tb_integer_alu_with_power.sv -----
// Testbench top for the integer ALU: clock, reset, request and result stimulus, and verdict.
module tb_integer_alu_with_power;
  import ialu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 680;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 250;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int STEADY_FIRST = 350;
  localparam int STEADY_LAST  = 470;

  localparam logic [MODE_W-1:0]  OP_UNUSED_FIRST = 4'd12;
  localparam logic [MODE_W-1:0]  OP_UNUSED_LAST  = 4'd15;
  localparam logic [FIELD_W-1:0] INT_MIN         = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] INT_MAX         = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] MINUS_ONE       = 32'hFFFF_FFFF;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  int                   mismatches;
  int                   outstanding;
  int                   requests_sent;
  bit                   steady_phase;
  bit                   hold_started;
  int                   hold_left;

  integer_alu_with_power i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  ialu_result_check i_result_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Offer one request, after an occasional gap, and hold it until the block takes it.
  task automatic send_request(input logic [MODE_W-1:0] op, input logic [FIELD_W-1:0] a,
                              input logic [FIELD_W-1:0] b);
    if (!steady_phase && $urandom_range(99) < 26) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, b, a, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
  endtask

  // Operand biased toward the extremes and small values.
  function automatic logic [FIELD_W-1:0] pick_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return FIELD_W'(1);
      2: return MINUS_ONE;
      3: return INT_MIN;
      4: return INT_MAX;
      5, 6: return FIELD_W'($urandom_range(64)) - FIELD_W'(32);
      default: return $urandom;
    endcase
  endfunction

  // One random request, with operands shaped to reach the cases of its operation.
  task automatic send_random_request();
    logic [MODE_W-1:0]  op;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    if ($urandom_range(99) < 3) begin
      op = OP_UNUSED_FIRST + MODE_W'($urandom_range(3));
    end else begin
      op = MODE_W'($urandom_range(OP_GT));
    end
    a = pick_operand();
    b = pick_operand();
    case (op)
      OP_POW: begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: b = FIELD_W'($urandom_range(40));
          6: begin
            // Negative exponent: the special bases minus one and one, or zero, or a random base.
            b = -FIELD_W'($urandom_range(1, 100));
            case ($urandom_range(3))
              0: a = MINUS_ONE;
              1: a = FIELD_W'(1);
              2: a = '0;
              default: a = $urandom;
            endcase
          end
          7: b = $urandom;
          8: b = '0;
          default: b = FIELD_W'($urandom_range(31, 32));
        endcase
      end
      OP_DIV, OP_REM: begin
        case ($urandom_range(19))
          0, 1, 2: b = '0;
          3, 4: begin
            b = MINUS_ONE;
            if ($urandom_range(1)) a = INT_MIN;
          end
          default: ;
        endcase
      end
      OP_EQ, OP_NE, OP_LT, OP_LE, OP_GE, OP_GT: begin
        if ($urandom_range(3) == 0) b = a;
      end
      default: ;
    endcase
    send_request(op, a, b);
  endtask

  // Result side: random stalls, one long hold-off, and a stretch with no stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_tready     <= 1'b0;
      hold_started <= 1'b0;
      hold_left    <= 0;
    end else if (!hold_started && requests_sent >= HOLD_AT) begin
      hold_started <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= steady_phase || ($urandom_range(99) >= 26);
    end
  end

  // Run limit.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // Reset, directed requests, random requests, drain and verdict.
  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    requests_sent = 0;
    steady_phase  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Extremes, wrapping, zero divisors, power special cases and unused codes.
    send_request(OP_ADD, INT_MAX, FIELD_W'(1));
    send_request(OP_SUB, INT_MIN, FIELD_W'(1));
    send_request(OP_MUL, INT_MAX, INT_MAX);
    send_request(OP_DIV, FIELD_W'(7), -FIELD_W'(2));
    send_request(OP_DIV, INT_MIN, MINUS_ONE);
    send_request(OP_DIV, INT_MAX, '0);
    send_request(OP_REM, -FIELD_W'(7), FIELD_W'(2));
    send_request(OP_REM, INT_MIN, MINUS_ONE);
    send_request(OP_REM, FIELD_W'(5), '0);
    send_request(OP_POW, '0, '0);
    send_request(OP_POW, FIELD_W'(3), FIELD_W'(5));
    send_request(OP_POW, MINUS_ONE, -FIELD_W'(3));
    send_request(OP_POW, MINUS_ONE, -FIELD_W'(2));
    send_request(OP_POW, FIELD_W'(1), -FIELD_W'(5));
    send_request(OP_POW, '0, MINUS_ONE);
    send_request(OP_POW, FIELD_W'(2), FIELD_W'(31));
    send_request(OP_POW, FIELD_W'(7), INT_MAX);
    send_request(OP_EQ, INT_MIN, INT_MIN);
    send_request(OP_NE, INT_MIN, INT_MAX);
    send_request(OP_LT, INT_MIN, INT_MAX);
    send_request(OP_LE, MINUS_ONE, MINUS_ONE);
    send_request(OP_GE, '0, MINUS_ONE);
    send_request(OP_GT, INT_MAX, INT_MIN);
    send_request(OP_UNUSED_FIRST, INT_MAX, INT_MAX);
    send_request(OP_UNUSED_LAST, MINUS_ONE, '0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady_phase = (i >= STEADY_FIRST) && (i < STEADY_LAST);
      send_random_request();
    end
    steady_phase = 1'b0;
    s_tvalid <= 1'b0;

    // Let the checker record the last request, wait for the results, then allow for a stray one.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
